// ===== rtl/rsie_pkg.sv =====
// shared types, widths and instruction codes of the instruction executor
package rsie_pkg;

    localparam int XLEN        = 32;
    localparam int REG_AW      = 5;
    localparam int NUM_REGS    = 1 << REG_AW;
    localparam int BANK_AW     = REG_AW - 1;
    localparam int BANK_DEPTH  = 1 << BANK_AW;
    localparam int MEM_ADDR_W  = 10;
    localparam int DATA_ADDR_W = MEM_ADDR_W;
    localparam int DATA_WORDS  = 1 << DATA_ADDR_W;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // major opcodes
    localparam logic [5:0] OP_RTYPE = 6'b000000;
    localparam logic [5:0] OP_ADDI  = 6'b001000;
    localparam logic [5:0] OP_LW    = 6'b100011;
    localparam logic [5:0] OP_SW    = 6'b101011;
    localparam logic [5:0] OP_BEQ   = 6'b000100;
    localparam logic [5:0] OP_LUI   = 6'b001111;
    localparam logic [5:0] OP_ANDI  = 6'b001100;
    localparam logic [5:0] OP_ORI   = 6'b001101;
    localparam logic [5:0] OP_SLTI  = 6'b001010;
    localparam logic [5:0] OP_SLTIU = 6'b001011;

    // function codes of the register format
    localparam logic [5:0] FN_ADD = 6'b100000;
    localparam logic [5:0] FN_SUB = 6'b100010;
    localparam logic [5:0] FN_AND = 6'b100100;
    localparam logic [5:0] FN_OR  = 6'b100101;
    localparam logic [5:0] FN_SLL = 6'b000000;
    localparam logic [5:0] FN_SRL = 6'b000010;
    localparam logic [5:0] FN_MUL = 6'b010010;

    typedef struct packed {
        logic [XLEN-1:0]       next_pc;
        logic                  reg_write;
        logic [REG_AW-1:0]     write_index;
        logic [XLEN-1:0]       write_value;
        logic                  high_write;
        logic [XLEN-1:0]       high_value;
        logic                  mem_write;
        logic [MEM_ADDR_W-1:0] mem_address;
        logic [XLEN-1:0]       mem_data;
    } result_t;

    function automatic logic [XLEN-1:0] sext16(input logic [15:0] v);
        return {{(XLEN-16){v[15]}}, v};
    endfunction

endpackage

// ===== rtl/risc_subset_instruction_executor.sv =====
// executor for an integer subset of a mips32-style instruction set
// a result passes register read, execute and writeback and is then offered from the result queue
// throughput: one instruction per cycle while s_ready is high, set by the banked register file read
//   and forward path and the single data store port used in execute
// results wait in a four-entry queue; input is taken while queued and in-flight results are under four
// reset: pc clears, register file reads zero through per-register valid flags,
//   data store keeps its contents, no clearing pass
module risc_subset_instruction_executor (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [31:0]                     s_instruction_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [31:0]                     m_next_pc,
    output logic                            m_reg_write,
    output logic [4:0]                      m_write_index,
    output logic [31:0]                     m_write_value,
    output logic                            m_high_write,
    output logic [31:0]                     m_high_value,
    output logic                            m_mem_write,
    output logic [rsie_pkg::MEM_ADDR_W-1:0] m_mem_address,
    output logic [31:0]                     m_mem_data
);

    typedef logic [rsie_pkg::XLEN-1:0]   word_t;
    typedef logic [rsie_pkg::REG_AW-1:0] ridx_t;
    typedef logic [rsie_pkg::QCNT_W:0]   qtot_t;

    // register file in two banks so that mul can write rd and rd+1 together
    word_t bank_even [rsie_pkg::BANK_DEPTH];
    word_t bank_odd  [rsie_pkg::BANK_DEPTH];
    word_t dmem      [rsie_pkg::DATA_WORDS];
    rsie_pkg::result_t q_mem [rsie_pkg::QDEPTH];

    logic [rsie_pkg::NUM_REGS-1:0] rvalid_reg;
    word_t pc_reg;
    logic  v1_reg, v2_reg;
    logic [31:0] instr1_reg;
    word_t ev_a_reg, od_a_reg, ev_b_reg, od_b_reg;
    logic  va_reg, vb_reg;
    logic  byp_a_hit_reg, byp_b_hit_reg;
    word_t byp_a_val_reg, byp_b_val_reg;
    rsie_pkg::result_t st2_reg;
    logic  is_load2_reg;
    ridx_t hidx2_reg;
    word_t dmem_rdata_reg;
    logic [rsie_pkg::QPTR_W-1:0] q_wptr_reg, q_rptr_reg;
    logic [rsie_pkg::QCNT_W-1:0] q_count_reg;

    logic  in_fire, pop, push;
    ridx_t rs0, rt0, rs1, rt1, rd1, hidx1;
    logic  wb_lo_en, wb_hi_en;
    ridx_t wb_lo_idx, wb_hi_idx;
    word_t wb_lo_val, wb_hi_val;
    logic  ev_we, od_we, ev_sel_lo, od_sel_lo;
    logic [rsie_pkg::BANK_AW-1:0] ev_waddr, od_waddr;
    word_t ev_wdata, od_wdata;
    logic  byp_a_hit, byp_b_hit;
    word_t byp_a_val, byp_b_val;
    word_t mem_a, mem_b, base_a, base_b, op_a, op_b, simm;
    logic [5:0] op1, fn1;
    logic [4:0] sh1;
    logic [15:0] imm1;
    logic signed [63:0] prod;
    word_t addr_sum;
    logic [rsie_pkg::DATA_ADDR_W-1:0] addr1;
    rsie_pkg::result_t res1, wb_rec;
    logic  is_load1, is_store1;
    qtot_t in_flight;

    assign in_fire = s_valid && s_ready;
    assign rs0 = s_instruction_word[25:21];
    assign rt0 = s_instruction_word[20:16];
    assign rs1 = instr1_reg[25:21];
    assign rt1 = instr1_reg[20:16];
    assign rd1 = instr1_reg[15:11];

    // ---------------- writeback (stage 2) ----------------
    assign wb_lo_en  = v2_reg && st2_reg.reg_write;
    assign wb_lo_idx = st2_reg.write_index;
    assign wb_lo_val = is_load2_reg ? dmem_rdata_reg : st2_reg.write_value;
    assign wb_hi_en  = v2_reg && st2_reg.high_write;
    assign wb_hi_idx = hidx2_reg;
    assign wb_hi_val = st2_reg.high_value;

    always_comb begin
        ev_sel_lo = wb_lo_en && !wb_lo_idx[0];
        od_sel_lo = wb_lo_en && wb_lo_idx[0];
        ev_we     = ev_sel_lo || (wb_hi_en && !wb_hi_idx[0]);
        od_we     = od_sel_lo || (wb_hi_en && wb_hi_idx[0]);
        ev_waddr  = ev_sel_lo ? wb_lo_idx[rsie_pkg::REG_AW-1:1] : wb_hi_idx[rsie_pkg::REG_AW-1:1];
        od_waddr  = od_sel_lo ? wb_lo_idx[rsie_pkg::REG_AW-1:1] : wb_hi_idx[rsie_pkg::REG_AW-1:1];
        ev_wdata  = ev_sel_lo ? wb_lo_val : wb_hi_val;
        od_wdata  = od_sel_lo ? wb_lo_val : wb_hi_val;
    end

    always_comb begin
        wb_rec = st2_reg;
        if (is_load2_reg) begin
            wb_rec.mem_data = dmem_rdata_reg;
            if (st2_reg.reg_write) begin
                wb_rec.write_value = dmem_rdata_reg;
            end
        end
    end

    assign push = v2_reg;

    // ---------------- register read (stage 0) ----------------
    always_ff @(posedge aclk) begin
        if (ev_we) begin
            bank_even[ev_waddr] <= ev_wdata;
        end
        if (in_fire) begin
            ev_a_reg <= bank_even[rs0[rsie_pkg::REG_AW-1:1]];
            ev_b_reg <= bank_even[rt0[rsie_pkg::REG_AW-1:1]];
        end
    end

    always_ff @(posedge aclk) begin
        if (od_we) begin
            bank_odd[od_waddr] <= od_wdata;
        end
        if (in_fire) begin
            od_a_reg <= bank_odd[rs0[rsie_pkg::REG_AW-1:1]];
            od_b_reg <= bank_odd[rt0[rsie_pkg::REG_AW-1:1]];
        end
    end

    // writes landing at the read edge are not seen by the banks
    always_comb begin
        byp_a_hit = (wb_lo_en && wb_lo_idx == rs0) || (wb_hi_en && wb_hi_idx == rs0);
        byp_a_val = (wb_lo_en && wb_lo_idx == rs0) ? wb_lo_val : wb_hi_val;
        byp_b_hit = (wb_lo_en && wb_lo_idx == rt0) || (wb_hi_en && wb_hi_idx == rt0);
        byp_b_val = (wb_lo_en && wb_lo_idx == rt0) ? wb_lo_val : wb_hi_val;
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            instr1_reg    <= s_instruction_word;
            va_reg        <= rvalid_reg[rs0];
            vb_reg        <= rvalid_reg[rt0];
            byp_a_hit_reg <= byp_a_hit;
            byp_a_val_reg <= byp_a_val;
            byp_b_hit_reg <= byp_b_hit;
            byp_b_val_reg <= byp_b_val;
        end
    end

    // ---------------- execute (stage 1) ----------------
    always_comb begin
        mem_a  = rs1[0] ? od_a_reg : ev_a_reg;
        mem_b  = rt1[0] ? od_b_reg : ev_b_reg;
        base_a = byp_a_hit_reg ? byp_a_val_reg : (va_reg ? mem_a : '0);
        base_b = byp_b_hit_reg ? byp_b_val_reg : (vb_reg ? mem_b : '0);
        // the instruction in writeback is the newest producer
        if (wb_lo_en && wb_lo_idx == rs1) begin
            op_a = wb_lo_val;
        end else if (wb_hi_en && wb_hi_idx == rs1) begin
            op_a = wb_hi_val;
        end else begin
            op_a = base_a;
        end
        if (wb_lo_en && wb_lo_idx == rt1) begin
            op_b = wb_lo_val;
        end else if (wb_hi_en && wb_hi_idx == rt1) begin
            op_b = wb_hi_val;
        end else begin
            op_b = base_b;
        end
    end

    assign op1      = instr1_reg[31:26];
    assign fn1      = instr1_reg[5:0];
    assign sh1      = instr1_reg[10:6];
    assign imm1     = instr1_reg[15:0];
    assign simm     = rsie_pkg::sext16(imm1);
    assign prod     = $signed(op_a) * $signed(op_b);
    assign addr_sum = op_a + simm;
    assign addr1    = addr_sum[rsie_pkg::DATA_ADDR_W-1:0];
    assign hidx1    = rd1 + 5'd1;

    always_comb begin
        res1 = '0;
        res1.next_pc = pc_reg + 32'd1;
        is_load1  = 1'b0;
        is_store1 = 1'b0;
        unique case (op1)
            rsie_pkg::OP_RTYPE: begin
                res1.write_index = rd1;
                res1.reg_write   = 1'b1;
                unique case (fn1)
                    rsie_pkg::FN_ADD: res1.write_value = op_a + op_b;
                    rsie_pkg::FN_SUB: res1.write_value = op_a - op_b;
                    rsie_pkg::FN_AND: res1.write_value = op_a & op_b;
                    rsie_pkg::FN_OR:  res1.write_value = op_a | op_b;
                    rsie_pkg::FN_SLL: res1.write_value = op_b << sh1;
                    rsie_pkg::FN_SRL: res1.write_value = op_b >> sh1;
                    rsie_pkg::FN_MUL: begin
                        res1.write_value = prod[31:0];
                        if (rd1 != 5'd31) begin
                            res1.high_write = 1'b1;
                            res1.high_value = prod[63:32];
                        end
                    end
                    default: res1.reg_write = 1'b0;
                endcase
            end
            rsie_pkg::OP_ADDI: begin
                res1.reg_write   = 1'b1;
                res1.write_index = rt1;
                res1.write_value = op_a + simm;
            end
            rsie_pkg::OP_ANDI: begin
                res1.reg_write   = 1'b1;
                res1.write_index = rt1;
                res1.write_value = op_a & {16'h0000, imm1};
            end
            rsie_pkg::OP_ORI: begin
                res1.reg_write   = 1'b1;
                res1.write_index = rt1;
                res1.write_value = op_a | {16'h0000, imm1};
            end
            rsie_pkg::OP_SLTI: begin
                res1.reg_write   = 1'b1;
                res1.write_index = rt1;
                res1.write_value = {31'd0, $signed(op_a) < $signed(simm)};
            end
            rsie_pkg::OP_SLTIU: begin
                res1.reg_write   = 1'b1;
                res1.write_index = rt1;
                res1.write_value = {31'd0, op_a < simm};
            end
            rsie_pkg::OP_LUI: begin
                res1.reg_write   = 1'b1;
                res1.write_index = rt1;
                res1.write_value = {imm1, 16'h0000};
            end
            rsie_pkg::OP_LW: begin
                // data comes from the store read in execute, registered for writeback
                res1.reg_write   = 1'b1;
                res1.write_index = rt1;
                res1.mem_address = addr1;
                is_load1         = 1'b1;
            end
            rsie_pkg::OP_SW: begin
                res1.mem_write   = 1'b1;
                res1.mem_address = addr1;
                res1.mem_data    = op_b;
                is_store1        = 1'b1;
            end
            rsie_pkg::OP_BEQ: begin
                if (op_a == op_b) begin
                    res1.next_pc = pc_reg + 32'd1 + simm;
                end
            end
            default: ;
        endcase
        if (res1.reg_write && res1.write_index == '0) begin
            res1.reg_write = 1'b0;
        end
        if (!res1.reg_write) begin
            res1.write_index = '0;
            res1.write_value = '0;
        end
    end

    // store writes in execute, so a following load already sees it
    always_ff @(posedge aclk) begin
        if (v1_reg && is_store1) begin
            dmem[addr1] <= op_b;
        end
        if (v1_reg && is_load1) begin
            dmem_rdata_reg <= dmem[addr1];
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            st2_reg      <= res1;
            is_load2_reg <= is_load1;
            hidx2_reg    <= hidx1;
        end
    end

    // ---------------- result queue ----------------
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[q_wptr_reg] <= wb_rec;
        end
    end

    assign m_valid   = q_count_reg != '0;
    assign pop       = m_valid && m_ready;
    assign in_flight = qtot_t'(q_count_reg) + qtot_t'(v1_reg) + qtot_t'(v2_reg);
    assign s_ready   = in_flight < qtot_t'(rsie_pkg::QDEPTH);

    assign m_next_pc     = q_mem[q_rptr_reg].next_pc;
    assign m_reg_write   = q_mem[q_rptr_reg].reg_write;
    assign m_write_index = q_mem[q_rptr_reg].write_index;
    assign m_write_value = q_mem[q_rptr_reg].write_value;
    assign m_high_write  = q_mem[q_rptr_reg].high_write;
    assign m_high_value  = q_mem[q_rptr_reg].high_value;
    assign m_mem_write   = q_mem[q_rptr_reg].mem_write;
    assign m_mem_address = q_mem[q_rptr_reg].mem_address;
    assign m_mem_data    = q_mem[q_rptr_reg].mem_data;

    // ---------------- control state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            pc_reg      <= '0;
            rvalid_reg  <= '0;
            q_wptr_reg  <= '0;
            q_rptr_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            v1_reg <= in_fire;
            v2_reg <= v1_reg;
            if (v1_reg) begin
                pc_reg <= res1.next_pc;
            end
            if (wb_lo_en) begin
                rvalid_reg[wb_lo_idx] <= 1'b1;
            end
            if (wb_hi_en) begin
                rvalid_reg[wb_hi_idx] <= 1'b1;
            end
            if (push) begin
                q_wptr_reg <= q_wptr_reg + 2'd1;
            end
            if (pop) begin
                q_rptr_reg <= q_rptr_reg + 2'd1;
            end
            if (push && !pop) begin
                q_count_reg <= q_count_reg + 3'd1;
            end else if (pop && !push) begin
                q_count_reg <= q_count_reg - 3'd1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        in_flight <= qtot_t'(rsie_pkg::QDEPTH))
        else $error("result queue would overflow");

    a_banks_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (wb_lo_en && wb_hi_en) |-> (wb_lo_idx[0] != wb_hi_idx[0]))
        else $error("both register writes hit one bank");

    a_zero_reg: assert property (@(posedge aclk) disable iff (!aresetn)
        !rvalid_reg[0])
        else $error("register zero was written");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count_reg == 3'(rsie_pkg::QDEPTH)) |-> !s_ready)
        else $error("transfer accepted with full result queue");
`endif

endmodule
